/* sv/ntc_pkg.sv */
// ntc_pkg: shared types, constants and the thermistor curve for the ntc temperature core
// no dependencies; imported by ntc_temperature_from_adc_core
package ntc_pkg;

	// parameter defaults and bounds
	localparam int SAMPLES_DEFAULT = 10;
	localparam int CURVE_DEFAULT   = 18;
	localparam int CURVE_MAX       = 64;

	// field widths
	localparam int SAMPLE_W = 10;
	localparam int SUM_W    = 14;
	localparam int ENTRY_W  = 13;
	localparam int RES_W    = 16;
	localparam int TEMP_W   = 12;
	localparam int STATUS_W = 2;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 14;

	// serial divider: dividend bits (sum*100 and diff*step*10 both stay below 2**21)
	localparam int DIV_BITS = 21;
	localparam int DIV_CNT_W = 5;

	localparam logic [RES_W-1:0] RES_MAX = 16'hFFFF;
	localparam int TEMP_MIN = -2048;
	localparam int TEMP_MAX = 2047;

	// register reset values
	localparam logic [7:0]  FIRST_TEMP_RESET = 8'hEC;   // -20 degrees
	localparam logic [4:0]  TEMP_STEP_RESET  = 5'd5;
	localparam logic [13:0] REF_SUM_RESET    = 14'd10210;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_FIRST_TEMP = 2'd0,
		CFG_TEMP_STEP  = 2'd1,
		CFG_REF_SUM    = 2'd2
	} cfg_index_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK       = 2'd0,
		ST_TOO_HOT  = 2'd1,
		ST_TOO_COLD = 2'd2
	} status_t;

	// descending resistance curve in units of 100 ohm; unused entries are zero
	function automatic logic [ENTRY_W-1:0] curve_entry(input logic [5:0] idx);
		logic [ENTRY_W-1:0] e;
		unique case (idx)
			6'd0:  e = 13'd4641;
			6'd1:  e = 13'd3490;
			6'd2:  e = 13'd2646;
			6'd3:  e = 13'd2023;
			6'd4:  e = 13'd1558;
			6'd5:  e = 13'd1209;
			6'd6:  e = 13'd945;
			6'd7:  e = 13'd744;
			6'd8:  e = 13'd589;
			6'd9:  e = 13'd470;
			6'd10: e = 13'd377;
			6'd11: e = 13'd304;
			6'd12: e = 13'd247;
			6'd13: e = 13'd201;
			6'd14: e = 13'd165;
			6'd15: e = 13'd136;
			6'd16: e = 13'd113;
			6'd17: e = 13'd94;
			default: e = '0;
		endcase
		return e;
	endfunction

endpackage

/* sv/ntc_temperature_from_adc_core.sv */
// ntc_temperature_from_adc_core: adc sample averaging, serial resistance divide,
// curve search and linear interpolation to tenths of a degree; uses ntc_pkg
//
// Each accepted adc word is added to a registered running sum. Every
// SAMPLES_PER_READING-th word closes a reading and starts the computation, during
// which the input is stalled: a check state, a bit-serial restoring divide for the
// resistance on a one-bit-per-cycle divider, a curve search of one entry per cycle,
// and for an interpolated point a setup state and a second divide on the same
// divider. An exact or interpolated point then passes a base step and a step to
// scale and saturate, and the done state loads the output register once it is
// free. A reading ends in the check when the sum reaches the reference, in the
// search when the resistance lies above the first entry or below the last one,
// and otherwise yields a temperature on an exact curve point or by interpolation.
// The result sits in an output register, so the next reading's words are taken
// while it waits on out_stall.
module ntc_temperature_from_adc_core
	import ntc_pkg::*;
#(
	parameter int SAMPLES_PER_READING = SAMPLES_DEFAULT,
	parameter int CURVE_ENTRIES       = CURVE_DEFAULT
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_write,
	input  logic [CFG_IDX_W-1:0]         cfg_index,
	input  logic [CFG_DATA_W-1:0]        cfg_data,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [SAMPLE_W-1:0]          adc_sample,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic signed [TEMP_W-1:0]     temperature_tenths,
	output logic [RES_W-1:0]             resistance_hundreds,
	output logic [STATUS_W-1:0]          status
);

	localparam int CNT_W = $clog2(SAMPLES_PER_READING + 1);
	localparam int IDX_W = $clog2(CURVE_ENTRIES + 1);

	typedef enum logic [7:0] {
		S_IDLE   = 8'b0000_0001,
		S_CHECK  = 8'b0000_0010,
		S_DIV    = 8'b0000_0100,
		S_SEARCH = 8'b0000_1000,
		S_PREP   = 8'b0001_0000,
		S_BASE   = 8'b0010_0000,
		S_SCALE  = 8'b0100_0000,
		S_DONE   = 8'b1000_0000
	} state_t;

	state_t state_q;

	// configuration
	logic signed [7:0] first_temp_q;
	logic [4:0]        temp_step_q;
	logic [8:0]        temp_step10_q;
	logic [13:0]       ref_sum_q;

	// accumulation
	logic [SUM_W-1:0] sum_q;
	logic [CNT_W-1:0] cnt_q;
	logic [SUM_W-1:0] reading_q;

	// divider
	logic [SUM_W-1:0]    rem_q;
	logic [SUM_W-1:0]    dvsr_q;
	logic [DIV_BITS-1:0] quo_q;
	logic [DIV_CNT_W-1:0] div_cnt_q;
	logic                second_q;

	// search and interpolation
	logic [IDX_W-1:0]    b_q;
	logic [ENTRY_W-1:0]  upper_q;
	logic [ENTRY_W-1:0]  diff_q;
	logic [ENTRY_W-1:0]  span_q;
	logic [8:0]          frac_q;
	logic signed [12:0]  base_q;

	// result
	logic [RES_W-1:0]         res_q;
	logic signed [TEMP_W-1:0] temp_q;
	logic [STATUS_W-1:0]      stat_q;

	logic                         out_valid_q;
	logic signed [TEMP_W-1:0]     out_temp_q;
	logic [RES_W-1:0]             out_res_q;
	logic [STATUS_W-1:0]          out_stat_q;

	// combinational helpers
	logic [SUM_W-1:0]    sum_next;
	logic [CNT_W-1:0]    cnt_next;
	logic [SUM_W:0]      trial;
	logic                trial_ge;
	logic [SUM_W-1:0]    rem_next;
	logic [DIV_BITS-1:0] quo_next;
	logic                div_last;
	logic [ENTRY_W-1:0]  entry;
	logic [10:0]         kstep;
	logic signed [16:0]  scaled;
	logic                in_take;
	logic                out_free;

	assign in_take  = in_valid && !in_stall;
	assign in_stall = (state_q != S_IDLE);
	assign out_free = !out_valid_q || !out_stall;

	assign sum_next = sum_q + SUM_W'(adc_sample);
	assign cnt_next = cnt_q + CNT_W'(1);

	// one restoring step per cycle
	assign trial    = {rem_q, quo_q[DIV_BITS-1]};
	assign trial_ge = (trial >= {1'b0, dvsr_q});
	assign rem_next = trial_ge ? SUM_W'(trial - {1'b0, dvsr_q}) : trial[SUM_W-1:0];
	assign quo_next = {quo_q[DIV_BITS-2:0], trial_ge};
	assign div_last = (div_cnt_q == DIV_CNT_W'(DIV_BITS - 1));

	assign entry  = curve_entry(6'(b_q));
	assign kstep  = 11'(b_q) * 11'(temp_step_q);
	assign scaled = 17'(base_q) * 17'sd10 + $signed({8'b0, frac_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_temp_q  <= FIRST_TEMP_RESET;
			temp_step_q   <= TEMP_STEP_RESET;
			temp_step10_q <= 9'(TEMP_STEP_RESET * 10);
			ref_sum_q     <= REF_SUM_RESET;
		end else if (cfg_write) begin
			unique case (cfg_index)
				CFG_FIRST_TEMP: first_temp_q <= cfg_data[7:0];
				CFG_TEMP_STEP: begin
					temp_step_q   <= cfg_data[4:0];
					temp_step10_q <= 9'(cfg_data[4:0]) * 9'd10;
				end
				CFG_REF_SUM: ref_sum_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			sum_q       <= '0;
			cnt_q       <= '0;
			div_cnt_q   <= '0;
			second_q    <= 1'b0;
			b_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// the done state reloads the output word itself
			if (out_valid_q && !out_stall && state_q != S_DONE)
				out_valid_q <= 1'b0;

			unique case (state_q)
				S_IDLE: begin
					if (in_take) begin
						if (cnt_next == CNT_W'(SAMPLES_PER_READING)) begin
							sum_q     <= '0;
							cnt_q     <= '0;
							reading_q <= sum_next;
							state_q   <= S_CHECK;
						end else begin
							sum_q <= sum_next;
							cnt_q <= cnt_next;
						end
					end
				end
				S_CHECK: begin
					if (reading_q >= ref_sum_q) begin
						res_q   <= RES_MAX;
						stat_q  <= ST_TOO_COLD;
						temp_q  <= '0;
						state_q <= S_DONE;
					end else begin
						rem_q     <= '0;
						quo_q     <= DIV_BITS'(reading_q) * DIV_BITS'(100);
						dvsr_q    <= ref_sum_q - reading_q;
						div_cnt_q <= '0;
						second_q  <= 1'b0;
						state_q   <= S_DIV;
					end
				end
				S_DIV: begin
					rem_q     <= rem_next;
					quo_q     <= quo_next;
					div_cnt_q <= div_cnt_q + DIV_CNT_W'(1);
					if (div_last) begin
						if (!second_q) begin
							res_q   <= (|quo_next[DIV_BITS-1:RES_W]) ? RES_MAX
							                                         : quo_next[RES_W-1:0];
							b_q     <= '0;
							state_q <= S_SEARCH;
						end else begin
							// fraction is below step*10, so nine bits hold it
							frac_q  <= quo_next[8:0];
							state_q <= S_BASE;
						end
					end
				end
				S_SEARCH: begin
					priority if (b_q == IDX_W'(CURVE_ENTRIES)) begin
						stat_q  <= ST_TOO_HOT;
						temp_q  <= '0;
						state_q <= S_DONE;
					end else if (res_q < RES_W'(entry)) begin
						upper_q <= entry;
						b_q     <= b_q + IDX_W'(1);
					end else if (res_q == RES_W'(entry)) begin
						frac_q  <= '0;
						state_q <= S_BASE;
					end else if (b_q == '0) begin
						stat_q  <= ST_TOO_COLD;
						temp_q  <= '0;
						state_q <= S_DONE;
					end else begin
						// res lies between upper and entry, so it fits the entry width
						diff_q  <= upper_q - res_q[ENTRY_W-1:0];
						span_q  <= upper_q - entry;
						b_q     <= b_q - IDX_W'(1);
						state_q <= S_PREP;
					end
				end
				S_PREP: begin
					rem_q     <= '0;
					quo_q     <= DIV_BITS'(diff_q) * DIV_BITS'(temp_step10_q);
					dvsr_q    <= SUM_W'(span_q);
					div_cnt_q <= '0;
					second_q  <= 1'b1;
					state_q   <= S_DIV;
				end
				S_BASE: begin
					base_q  <= 13'(first_temp_q) + $signed({2'b00, kstep});
					state_q <= S_SCALE;
				end
				S_SCALE: begin
					stat_q <= ST_OK;
					if (scaled < 17'(TEMP_MIN))
						temp_q <= TEMP_W'(TEMP_MIN);
					else if (scaled > 17'(TEMP_MAX))
						temp_q <= TEMP_W'(TEMP_MAX);
					else
						temp_q <= scaled[TEMP_W-1:0];
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_temp_q  <= temp_q;
						out_res_q   <= res_q;
						out_stat_q  <= stat_q;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid           = out_valid_q;
	assign temperature_tenths  = out_temp_q;
	assign resistance_hundreds = out_res_q;
	assign status              = out_stat_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q < CNT_W'(SAMPLES_PER_READING))
		else $error("sample count reached the reading length");

	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DIV |-> rem_q < dvsr_q)
		else $error("divider remainder not below divisor");

	a_search_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SEARCH |-> b_q <= IDX_W'(CURVE_ENTRIES))
		else $error("curve search ran past the last entry");

	a_load_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_DONE))
		else $error("result word loaded outside the done state");

	a_flag_temp_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_stat_q != ST_OK |-> out_temp_q == '0)
		else $error("flagged result carries a temperature");

endmodule

/* tb/sv/tb_ntc_temperature_from_adc_core.sv */
`timescale 1ns / 1ps
// tb_ntc_temperature_from_adc_core: self-checking bench for the ntc temperature core,
// with its own reading predictor, random idling, long output hold-off and register phases
// depends on ntc_pkg and ntc_temperature_from_adc_core
module tb_ntc_temperature_from_adc_core;
	import ntc_pkg::*;

	localparam int WORDS_PER_READING = SAMPLES_DEFAULT;
	localparam int CURVE_LEN         = CURVE_DEFAULT;
	localparam int MAX_SUM           = WORDS_PER_READING * 1023;
	localparam int SETTLE_CYCLES     = 100;

	typedef struct packed {
		logic signed [TEMP_W-1:0] temperature;
		logic [RES_W-1:0]         resistance;
		status_t                  status;
	} reading_t;

	typedef enum {RD_RAW, RD_CURVE_HIT, RD_IN_CURVE, RD_NEAR_REF, RD_ANY_SUM} reading_kind_t;

	logic                  clk;
	logic                  arst_n     = 1'b0;
	logic                  cfg_write  = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index  = '0;
	logic [CFG_DATA_W-1:0] cfg_data   = '0;
	logic                  in_valid   = 1'b0;
	logic                  in_stall;
	logic [SAMPLE_W-1:0]   adc_sample = '0;
	logic                  out_valid;
	logic                  out_stall  = 1'b0;
	logic signed [TEMP_W-1:0] temperature_tenths;
	logic [RES_W-1:0]      resistance_hundreds;
	logic [STATUS_W-1:0]   status;

	int unsigned thermistor_curve [CURVE_LEN] = '{
		4641, 3490, 2646, 2023, 1558, 1209, 945, 744, 589,
		470, 377, 304, 247, 201, 165, 136, 113, 94
	};

	// predictor state and register copies
	logic [SUM_W-1:0] acc_sum        = '0;
	int               acc_count      = 0;
	logic [7:0]       cur_first_temp = FIRST_TEMP_RESET;
	logic [4:0]       cur_temp_step  = TEMP_STEP_RESET;
	logic [13:0]      cur_ref_sum    = REF_SUM_RESET;

	reading_t pending_readings [$];
	int       errors     = 0;
	bit       quiet      = 1'b0;
	int       hold_left  = 0;
	int       burst_left = 0;

	ntc_temperature_from_adc_core DUT (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cfg_write           (cfg_write),
		.cfg_index           (cfg_index),
		.cfg_data            (cfg_data),
		.in_valid            (in_valid),
		.in_stall            (in_stall),
		.adc_sample          (adc_sample),
		.out_valid           (out_valid),
		.out_stall           (out_stall),
		.temperature_tenths  (temperature_tenths),
		.resistance_hundreds (resistance_hundreds),
		.status              (status)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	function automatic int unsigned resistance_of(int unsigned s);
		int unsigned r;
		int unsigned refv;
		refv = 32'(cur_ref_sum);
		if (s >= refv)
			return 32'(RES_MAX);
		r = (s * 100) / (refv - s);
		return (r > 32'(RES_MAX)) ? 32'(RES_MAX) : r;
	endfunction

	function automatic reading_t predict_reading(int unsigned s);
		reading_t    rd;
		int unsigned r, upper, span, frac;
		int          b, t, base;
		t = 0;
		rd.status = ST_OK;
		r = resistance_of(s);
		base = int'($signed(cur_first_temp));
		if (s >= 32'(cur_ref_sum)) begin
			rd.status = ST_TOO_COLD;
		end else begin
			b = 0;
			while (b < CURVE_LEN && r < thermistor_curve[b])
				b++;
			if (b >= CURVE_LEN) begin
				rd.status = ST_TOO_HOT;
			end else if (r == thermistor_curve[b]) begin
				t = (base + b * int'(cur_temp_step)) * 10;
			end else if (b == 0) begin
				rd.status = ST_TOO_COLD;
			end else begin
				upper = thermistor_curve[b-1];
				span = upper - thermistor_curve[b];
				frac = ((upper - r) * 32'(cur_temp_step) * 10) / span;
				t = (base + (b - 1) * int'(cur_temp_step)) * 10 + int'(frac);
			end
			if (t < TEMP_MIN)
				t = TEMP_MIN;
			if (t > TEMP_MAX)
				t = TEMP_MAX;
		end
		rd.temperature = t[TEMP_W-1:0];
		rd.resistance = r[RES_W-1:0];
		return rd;
	endfunction

	task automatic send_word(input logic [SAMPLE_W-1:0] w);
		if (!quiet && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		in_valid <= 1'b1;
		adc_sample <= w;
		do @(posedge clk); while (in_stall !== 1'b0);
		acc_sum = acc_sum + SUM_W'(w);
		acc_count++;
		if (acc_count == WORDS_PER_READING) begin
			pending_readings.push_back(predict_reading(32'(acc_sum)));
			acc_sum = '0;
			acc_count = 0;
		end
	endtask

	// spread a target sum over one reading's words, each within 0..1023
	task automatic send_sum(input int s);
		int rem, lo, hi, w;
		rem = s;
		for (int i = 0; i < WORDS_PER_READING; i++) begin
			lo = rem - 1023 * (WORDS_PER_READING - 1 - i);
			if (lo < 0)
				lo = 0;
			hi = (rem < 1023) ? rem : 1023;
			w = $urandom_range(hi, lo);
			send_word(w[SAMPLE_W-1:0]);
			rem -= w;
		end
	endtask

	task automatic send_reading(input reading_kind_t kind);
		int          s, r, est, c, d;
		int unsigned refv;
		refv = 32'(cur_ref_sum);
		s = 0;
		if (kind == RD_RAW) begin
			repeat (WORDS_PER_READING) send_word(SAMPLE_W'($urandom_range(0, 1023)));
		end else begin
			case (kind)
				RD_CURVE_HIT, RD_IN_CURVE: begin
					if (kind == RD_CURVE_HIT) begin
						r = thermistor_curve[$urandom_range(0, CURVE_LEN - 1)];
						if ($urandom_range(0, 3) == 0)
							r = r + int'($urandom_range(0, 2)) - 1;
					end else begin
						r = $urandom_range(thermistor_curve[0] + 200,
							thermistor_curve[CURVE_LEN-1] - 20);
					end
					// invert the divide, then look nearby for a sum that lands exactly on r
					est = int'((longint'(r) * refv) / (100 + r));
					s = est;
					for (d = -3; d <= 3; d++) begin
						c = est + d;
						if (c >= 0 && c <= MAX_SUM && c < refv && resistance_of(c) == r)
							s = c;
					end
				end
				RD_NEAR_REF: s = int'(refv) + int'($urandom_range(0, 8)) - 4;
				default:     s = $urandom_range(0, MAX_SUM);
			endcase
			if (s < 0)
				s = 0;
			if (s > MAX_SUM)
				s = MAX_SUM;
			send_sum(s);
		end
	endtask

	task automatic send_mixed(input int n);
		int pick;
		repeat (n) begin
			pick = $urandom_range(0, 99);
			if (pick < 25)
				send_reading(RD_CURVE_HIT);
			else if (pick < 60)
				send_reading(RD_IN_CURVE);
			else if (pick < 70)
				send_reading(RD_NEAR_REF);
			else if (pick < 85)
				send_reading(RD_ANY_SUM);
			else
				send_reading(RD_RAW);
		end
	endtask

	// registers change only with the core drained and quiet
	task automatic apply_setting(input logic [7:0] ft, input logic [4:0] step,
			input logic [13:0] rs);
		in_valid <= 1'b0;
		while (pending_readings.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= CFG_FIRST_TEMP;
		cfg_data <= CFG_DATA_W'(ft);
		@(posedge clk);
		cur_first_temp = ft;
		cfg_index <= CFG_TEMP_STEP;
		cfg_data <= CFG_DATA_W'(step);
		@(posedge clk);
		cur_temp_step = step;
		cfg_index <= CFG_REF_SUM;
		cfg_data <= CFG_DATA_W'(rs);
		@(posedge clk);
		cur_ref_sum = rs;
		cfg_write <= 1'b0;
	endtask

	task automatic test_reset_defaults();
		// full-scale words overrun the reference, zero words fall past the hot end
		repeat (WORDS_PER_READING) send_word(10'h3FF);
		repeat (WORDS_PER_READING) send_word(10'h000);
	endtask

	task automatic test_curve_points();
		repeat (8) send_reading(RD_CURVE_HIT);
		repeat (4) send_reading(RD_IN_CURVE);
	endtask

	task automatic test_config_extremes();
		apply_setting(8'h80, 5'd1, 14'd1);
		send_sum(0);
		repeat (2) send_reading(RD_ANY_SUM);
		apply_setting(8'h7F, 5'd31, 14'd16383);
		repeat (2) send_reading(RD_CURVE_HIT);
		send_mixed(4);
		apply_setting(8'h80, 5'd31, REF_SUM_RESET);
		send_mixed(3);
	endtask

	task automatic test_resistance_saturation();
		apply_setting(FIRST_TEMP_RESET, TEMP_STEP_RESET, 14'($urandom_range(700, 3000)));
		repeat (4) send_reading(RD_NEAR_REF);
	endtask

	task automatic test_random_settings();
		logic [13:0] rs;
		repeat (4) begin
			if ($urandom_range(0, 3) == 0)
				rs = 14'($urandom_range(1, 16383));
			else
				rs = 14'($urandom_range(9000, 16383));
			apply_setting(8'($urandom_range(0, 255)), 5'($urandom_range(1, 31)), rs);
			send_mixed(5);
		end
	endtask

	task automatic test_output_backpressure();
		apply_setting(FIRST_TEMP_RESET, TEMP_STEP_RESET, REF_SUM_RESET);
		hold_left = 600;
		send_mixed(6);
	endtask

	task automatic test_no_idling();
		quiet = 1'b1;
		send_mixed(8);
	endtask

	// receiver side: long hold-off on request, no stalls while quiet, otherwise random stall bursts
	initial begin
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else if (quiet) begin
				out_stall <= 1'b0;
			end else if (burst_left > 0) begin
				out_stall <= 1'b1;
				burst_left--;
			end else if ($urandom_range(0, 5) == 0) begin
				out_stall <= 1'b1;
				burst_left = $urandom_range(1, 5) - 1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin : check_word
		reading_t exp_rd;
		if (arst_n && out_valid === 1'b1 && out_stall == 1'b0) begin
			if (pending_readings.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected word: temp %0d res %0d status %0d",
						temperature_tenths, resistance_hundreds, status);
			end else begin
				exp_rd = pending_readings.pop_front();
				if (temperature_tenths !== exp_rd.temperature
						|| resistance_hundreds !== exp_rd.resistance
						|| status !== exp_rd.status) begin
					errors++;
					if (errors <= 10)
						$display("mismatch: temp exp %0d got %0d, res exp %0d got %0d, %s",
							exp_rd.temperature, temperature_tenths, exp_rd.resistance,
							resistance_hundreds,
							$sformatf("status exp %0d got %0d", exp_rd.status, status));
				end
			end
		end
	end

	initial begin
		int wait_cycles;
		wait_cycles = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_curve_points();
		test_config_extremes();
		test_resistance_saturation();
		test_random_settings();
		test_output_backpressure();
		test_no_idling();
		in_valid <= 1'b0;
		while (pending_readings.size() != 0 && wait_cycles < 100000) begin
			@(posedge clk);
			wait_cycles++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
		errors += pending_readings.size();
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
